@@ rtl/frame_mean_covariance_accumulator_core_assert.svh @@
// Assertion macros used by the checker file of the accumulator.
`ifndef FRAME_MEAN_COVARIANCE_ACCUMULATOR_CORE_ASSERT_SVH
`define FRAME_MEAN_COVARIANCE_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FMCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmca: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FMCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmca: next-cycle check failed");

`endif

@@ rtl/fmca_pkg.sv @@
// Shared constants and types of the frame mean and covariance accumulator.
package fmca_pkg;

    localparam int MAX_DIM    = 64;
    localparam int COUNT_BITS = 20;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 36;
    localparam int CROSS_W    = 52;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int DIM_AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int TRI_DEPTH  = (MAX_DIM * (MAX_DIM + 1)) / 2;
    localparam int TRI_AW     = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
    localparam int DIV_W      = CROSS_W + 1;
    localparam int QUO_W      = DIV_W + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_COMMIT    = 3'd0,
        ST_LEN_ERR   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_READ_OK   = 3'd4,
        ST_NO_FRAMES = 3'd5
    } t_status;

endpackage

@@ rtl/fmca_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fmca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fmca_rdiv.sv @@
// Bit-serial signed divider by the frame count, rounding to nearest, ties away from zero.
module fmca_rdiv (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [fmca_pkg::DIV_W-1:0]      i_num,
    input  logic [fmca_pkg::COUNT_BITS-1:0]        i_den,
    output logic                                   o_done,
    output logic signed [fmca_pkg::QUO_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(fmca_pkg::DIV_W + 1);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_neg;
    logic [CNT_W-1:0]                   r_cnt;
    logic [fmca_pkg::DIV_W-1:0]         r_dvd;
    logic [fmca_pkg::COUNT_BITS-1:0]    r_rem;
    logic [fmca_pkg::COUNT_BITS-1:0]    r_den;
    logic [fmca_pkg::DIV_W-1:0]         n_mag;
    logic [fmca_pkg::COUNT_BITS:0]      n_trial;
    logic                               n_qbit;

    always_comb begin
        n_mag   = i_num[fmca_pkg::DIV_W-1] ? fmca_pkg::DIV_W'(-i_num) : fmca_pkg::DIV_W'(i_num);
        n_trial = {r_rem, r_dvd[fmca_pkg::DIV_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(fmca_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The quotient shifts into the dividend register as the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[fmca_pkg::DIV_W-1];
            r_dvd <= n_mag + fmca_pkg::DIV_W'(i_den >> 1);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_qbit ? fmca_pkg::COUNT_BITS'(n_trial - {1'b0, r_den})
                            : fmca_pkg::COUNT_BITS'(n_trial);
            r_dvd <= {r_dvd[fmca_pkg::DIV_W-2:0], n_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});

endmodule

@@ rtl/frame_mean_covariance_accumulator_core.sv @@
// Frame mean / covariance accumulator: sum and lower-triangle cross-product stores in RAM.
//
// Input stream (i_s_*): one item per request. tuser is the kind (add element, remove
// element, read entry, unused); tlast marks the last element of a frame; tdata carries
// the Q8.8 sample and the row and column of a read. Config channel (i_cfg_*) writes the
// frame length and is always ready.
// Output stream (o_m_*): one result per completed frame and per read; tuser is status.
// Element items that are not last give no result.
// A committed frame of n elements walks the sum and the n(n+1)/2 cross entries through
// one 16x16 multiplier, in states CI0 and CI1 per row and CJ0, CJ1 and CJ2 per cross entry.
// A read that finds frames runs three 53-step serial divisions by the count.
// After reset the block clears both stores, one entry per cycle, with o_s_tready low.
// A result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile and its own result waits until the register frees.
module frame_mean_covariance_accumulator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Config write: frame length.
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [6:0]    i_cfg_data,
    // Input stream.
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [31:0]   i_s_tdata,   // sample[15:0], row[21:16], col[27:22], zero
    input  logic          i_s_tlast,
    input  logic [1:0]    i_s_tuser,   // kind
    // Output stream.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [159:0]  o_m_tdata,   // sum_value[35:0], cross_sum[87:36],
                                       // frame_count[107:88], mean_value[123:108],
                                       // covariance_value[155:124], zero
    output logic [2:0]    o_m_tuser    // status
);

    localparam int CW = fmca_pkg::COUNT_BITS;
    localparam int AW = fmca_pkg::DIM_AW;
    localparam int TW = fmca_pkg::TRI_AW;
    localparam int LW = fmca_pkg::LEN_W;
    localparam int QW = fmca_pkg::QUO_W;

    typedef enum logic [15:0] {
        S_CLR  = 16'h0001,
        S_IDLE = 16'h0002,
        S_CI0  = 16'h0004,
        S_CI1  = 16'h0008,
        S_CJ0  = 16'h0010,
        S_CJ1  = 16'h0020,
        S_CJ2  = 16'h0040,
        S_RA   = 16'h0080,
        S_RB   = 16'h0100,
        S_RC   = 16'h0200,
        S_DM   = 16'h0400,
        S_DC   = 16'h0800,
        S_DX   = 16'h1000,
        S_MUL  = 16'h2000,
        S_COV  = 16'h4000,
        S_EMIT = 16'h8000
    } t_state;

    t_state                         r_state, n_state;
    logic [LW-1:0]                  r_vlen;
    logic [6:0]                     r_pos;
    logic                           r_dir;
    logic [CW-1:0]                  r_frames;
    logic [TW-1:0]                  r_clr;
    logic [AW-1:0]                  r_i, r_j;
    logic [TW-1:0]                  r_k;
    logic [LW-1:0]                  r_len;
    logic signed [15:0]             r_vi;
    logic signed [31:0]             r_prod;
    logic [fmca_pkg::CROSS_W-1:0]   r_xold;
    logic [fmca_pkg::IDX_W-1:0]     r_row, r_col;
    logic [fmca_pkg::SUM_W-1:0]     r_s, r_sc;
    logic [fmca_pkg::CROSS_W-1:0]   r_x;
    logic signed [15:0]             r_mr, r_mc;
    logic signed [QW-1:0]           r_xt;
    logic signed [31:0]             r_mm;
    fmca_pkg::t_status              r_res_status;
    logic [fmca_pkg::SUM_W-1:0]     r_res_sum;
    logic [fmca_pkg::CROSS_W-1:0]   r_res_cross;
    logic [15:0]                    r_res_mean;
    logic [31:0]                    r_res_cov;
    logic                           r_oval;
    logic [159:0]                   r_otdata;
    logic [2:0]                     r_otuser;

    // RAM ports.
    logic                           fb_we;
    logic [AW-1:0]                  fb_waddr, fb_raddr;
    logic [15:0]                    fb_rdata;
    logic                           sum_we;
    logic [AW-1:0]                  sum_waddr, sum_raddr;
    logic [fmca_pkg::SUM_W-1:0]     sum_wdata, sum_rdata;
    logic                           x_we;
    logic [TW-1:0]                  x_waddr, x_raddr;
    logic [fmca_pkg::CROSS_W-1:0]   x_wdata, x_rdata;

    logic                           div_start, div_done;
    logic signed [fmca_pkg::DIV_W-1:0] div_num;
    logic signed [QW-1:0]           div_quo;

    logic                           s_acc, emit_load;
    fmca_pkg::t_kind                in_kind;
    logic [fmca_pkg::IDX_W-1:0]     in_row, in_col;
    logic                           dir_now;
    logic [7:0]                     flen;
    logic [LW-1:0]                  eff_len;
    fmca_pkg::t_status              frame_status;
    logic                           last_ij;
    logic [TW-1:0]                  tri_k;
    logic signed [QW:0]             cov_diff;

    function automatic logic [15:0] sat16(input logic signed [QW-1:0] v);
        logic [QW-16:0] hi;
        hi = v[QW-1:15];
        if ((&hi) || !(|hi)) begin
            return v[15:0];
        end
        return v[QW-1] ? 16'h8000 : 16'h7fff;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [QW:0] v);
        logic [QW-31:0] hi;
        hi = v[QW:31];
        if ((&hi) || !(|hi)) begin
            return v[31:0];
        end
        return v[QW] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign emit_load   = (r_state == S_EMIT) && (!r_oval || i_m_tready);

    always_comb begin
        in_kind = fmca_pkg::t_kind'(i_s_tuser);
        in_row  = i_s_tdata[21:16];
        in_col  = i_s_tdata[27:22];
        dir_now = (r_pos == 7'd0) ? i_s_tuser[0] : r_dir;
        flen    = {1'b0, r_pos} + 8'd1;
        if (r_vlen == '0) begin
            eff_len = LW'(1);
        end else if (int'(r_vlen) > fmca_pkg::MAX_DIM) begin
            eff_len = LW'(fmca_pkg::MAX_DIM);
        end else begin
            eff_len = r_vlen;
        end
        if (flen != {1'b0, eff_len}) begin
            frame_status = fmca_pkg::ST_LEN_ERR;
        end else if (dir_now && (r_frames == '0)) begin
            frame_status = fmca_pkg::ST_EMPTY;
        end else if (!dir_now && (r_frames >= fmca_pkg::COUNT_FULL)) begin
            frame_status = fmca_pkg::ST_FULL;
        end else begin
            frame_status = fmca_pkg::ST_COMMIT;
        end
        last_ij  = (r_j == r_i) && ((LW'(r_i) + LW'(1)) == r_len);
        tri_k    = TW'(((32'(r_row) * (32'(r_row) + 32'd1)) >> 1) + 32'(r_col));
        cov_diff = {r_xt[QW-1], r_xt} - (QW+1)'(r_mm);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr == TW'(fmca_pkg::TRI_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (in_kind == fmca_pkg::KIND_READ) begin
                        n_state = S_RA;
                    end else if ((in_kind != fmca_pkg::KIND_NONE) && i_s_tlast) begin
                        n_state = (frame_status == fmca_pkg::ST_COMMIT) ? S_CI0 : S_EMIT;
                    end
                end
            end
            S_CI0:  n_state = S_CI1;
            S_CI1:  n_state = S_CJ0;
            S_CJ0:  n_state = S_CJ1;
            S_CJ1:  n_state = S_CJ2;
            S_CJ2: begin
                if (r_j != r_i) begin
                    n_state = S_CJ0;
                end else if (last_ij) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_CI0;
                end
            end
            S_RA:   n_state = S_RB;
            S_RB:   n_state = S_RC;
            S_RC:   n_state = (r_frames == '0) ? S_EMIT : S_DM;
            S_DM:   n_state = div_done ? S_DC : S_DM;
            S_DC:   n_state = div_done ? S_DX : S_DC;
            S_DX:   n_state = div_done ? S_MUL : S_DX;
            S_MUL:  n_state = S_COV;
            S_COV:  n_state = S_EMIT;
            S_EMIT: n_state = emit_load ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // RAM and divider controls.
    always_comb begin
        fb_we     = 1'b0;
        fb_waddr  = AW'(r_pos);
        fb_raddr  = (r_state == S_CJ0) ? r_j : r_i;
        sum_we    = 1'b0;
        sum_waddr = r_i;
        sum_wdata = '0;
        sum_raddr = r_i;
        x_we      = 1'b0;
        x_waddr   = r_k;
        x_wdata   = '0;
        x_raddr   = r_k;
        div_start = 1'b0;
        div_num   = '0;
        case (r_state)
            S_CLR: begin
                x_we      = 1'b1;
                x_waddr   = r_clr;
                sum_we    = (int'(r_clr) < fmca_pkg::MAX_DIM);
                sum_waddr = AW'(r_clr);
            end
            S_IDLE: begin
                fb_we = s_acc && !in_kind[1] && (int'(r_pos) < fmca_pkg::MAX_DIM);
            end
            S_CI1: begin
                sum_we    = 1'b1;
                sum_wdata = r_dir ? sum_rdata - fmca_pkg::SUM_W'($signed(fb_rdata))
                                  : sum_rdata + fmca_pkg::SUM_W'($signed(fb_rdata));
            end
            S_CJ2: begin
                x_we    = 1'b1;
                x_wdata = r_dir ? r_xold - fmca_pkg::CROSS_W'(r_prod)
                                : r_xold + fmca_pkg::CROSS_W'(r_prod);
            end
            S_RA: begin
                sum_raddr = AW'(r_row);
                x_raddr   = tri_k;
            end
            S_RB: begin
                sum_raddr = AW'(r_col);
            end
            S_RC: begin
                div_start = (r_frames != '0);
                div_num   = fmca_pkg::DIV_W'($signed(r_s));
            end
            S_DM: begin
                div_start = div_done;
                div_num   = fmca_pkg::DIV_W'($signed(r_sc));
            end
            S_DC: begin
                div_start = div_done;
                div_num   = fmca_pkg::DIV_W'($signed(r_x));
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_vlen   <= LW'(fmca_pkg::MAX_DIM);
            r_pos    <= '0;
            r_dir    <= 1'b0;
            r_frames <= '0;
            r_clr    <= '0;
            r_oval   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_vlen <= i_cfg_data;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + TW'(1);
            end
            if (s_acc && !in_kind[1]) begin
                r_dir <= dir_now;
                if (!i_s_tlast) begin
                    if (r_pos != 7'd127) begin
                        r_pos <= r_pos + 7'd1;
                    end
                end else begin
                    r_pos <= '0;
                end
            end
            if ((r_state == S_CJ2) && last_ij) begin
                r_frames <= r_dir ? r_frames - CW'(1) : r_frames + CW'(1);
            end
            if (emit_load) begin
                r_oval <= 1'b1;
            end else if (i_m_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_i   <= '0;
                r_j   <= '0;
                r_k   <= '0;
                r_len <= eff_len;
                if (in_col > in_row) begin
                    r_row <= in_col;
                    r_col <= in_row;
                end else begin
                    r_row <= in_row;
                    r_col <= in_col;
                end
                r_res_status <= frame_status;
                r_res_sum    <= '0;
                r_res_cross  <= '0;
                r_res_mean   <= '0;
                r_res_cov    <= '0;
            end
            S_CI1: begin
                r_vi <= $signed(fb_rdata);
                r_j  <= '0;
            end
            S_CJ1: begin
                r_prod <= r_vi * $signed(fb_rdata);
                r_xold <= x_rdata;
            end
            S_CJ2: begin
                r_k <= r_k + TW'(1);
                if (r_j != r_i) begin
                    r_j <= r_j + AW'(1);
                end else begin
                    r_i <= r_i + AW'(1);
                end
            end
            S_RB: begin
                r_s <= (int'(r_row) < fmca_pkg::MAX_DIM) ? sum_rdata : '0;
                r_x <= (int'(r_row) < fmca_pkg::MAX_DIM) ? x_rdata : '0;
            end
            S_RC: begin
                r_sc         <= (int'(r_col) < fmca_pkg::MAX_DIM) ? sum_rdata : '0;
                r_res_status <= fmca_pkg::ST_NO_FRAMES;
                r_res_sum    <= r_s;
                r_res_cross  <= r_x;
            end
            S_DM: begin
                if (div_done) begin
                    r_mr <= $signed(sat16(div_quo));
                end
            end
            S_DC: begin
                if (div_done) begin
                    r_mc <= $signed(sat16(div_quo));
                end
            end
            S_DX: begin
                if (div_done) begin
                    r_xt <= div_quo;
                end
            end
            S_MUL: begin
                r_mm <= r_mr * r_mc;
            end
            S_COV: begin
                r_res_status <= fmca_pkg::ST_READ_OK;
                r_res_mean   <= r_mr;
                r_res_cov    <= sat32(cov_diff);
            end
            default: begin
            end
        endcase
        if (emit_load) begin
            r_otuser <= r_res_status;
            r_otdata <= {4'b0, r_res_cov, r_res_mean, 20'(r_frames), r_res_cross, r_res_sum};
        end
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = r_otdata;
    assign o_m_tuser  = r_otuser;

    fmca_ram #(.WIDTH(16), .DEPTH(fmca_pkg::MAX_DIM)) u_fb_ram (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (i_s_tdata[15:0]),
        .i_raddr (fb_raddr),
        .o_rdata (fb_rdata)
    );

    fmca_ram #(.WIDTH(fmca_pkg::SUM_W), .DEPTH(fmca_pkg::MAX_DIM)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    fmca_ram #(.WIDTH(fmca_pkg::CROSS_W), .DEPTH(fmca_pkg::TRI_DEPTH)) u_cross_ram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (x_waddr),
        .i_wdata (x_wdata),
        .i_raddr (x_raddr),
        .o_rdata (x_rdata)
    );

    fmca_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_frames),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

endmodule

@@ rtl/fmca_check.sv @@
// Port-level checker for the accumulator, bound to the top level.
`include "frame_mean_covariance_accumulator_core_assert.svh"

module fmca_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  logic [159:0]  o_m_tdata,
    input  logic [2:0]    o_m_tuser
);

    // A stalled result holds.
    `FMCA_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // Mean and covariance are zero unless a read found frames.
    `FMCA_ASSERT_IMP(a_stat_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != fmca_pkg::ST_READ_OK), o_m_tdata[155:108] == '0)

    // Frame results carry no sum or cross sum.
    `FMCA_ASSERT_IMP(a_frame_zero, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser[2] == 1'b0), o_m_tdata[87:0] == '0)

    // A read with no frames reports a zero count.
    `FMCA_ASSERT_IMP(a_no_frames, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == fmca_pkg::ST_NO_FRAMES), o_m_tdata[107:88] == '0)

endmodule

bind frame_mean_covariance_accumulator_core fmca_check u_fmca_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

@@ bench/frame_mean_covariance_accumulator_core_tb.sv @@
// Self-checking testbench of the frame mean and covariance accumulator core.
`timescale 1ns / 100ps

module frame_mean_covariance_accumulator_core_tb;

    localparam int STALL_LIMIT = 40000;

    typedef struct {
        fmca_pkg::t_status  status;
        logic signed [35:0] sum_value;
        logic signed [51:0] cross_sum;
        logic [19:0]        frame_count;
        logic signed [15:0] mean_value;
        logic signed [31:0] covariance_value;
    } t_stat;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [6:0]   i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata;
    logic         i_s_tlast;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [159:0] o_m_tdata;
    logic [2:0]   o_m_tuser;

    // Predictor state.
    logic [6:0]          frame_len_reg;
    logic [15:0]         elem_buf [fmca_pkg::MAX_DIM];
    int unsigned         elem_pos;
    bit                  removing;
    logic [35:0]         dim_sum [fmca_pkg::MAX_DIM];
    logic [51:0]         pair_sum [fmca_pkg::TRI_DEPTH];
    int unsigned         frames_in;

    t_stat       expected_stats[$];
    int          sender_idle;
    int          receiver_idle;
    int          errors;
    int          stall_cycles;
    int          items_sent;

    frame_mean_covariance_accumulator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int tri_index(int r, int c);
        return (r * (r + 1)) / 2 + c;
    endfunction

    function automatic int effective_len();
        if (frame_len_reg == 0) return 1;
        if (frame_len_reg > fmca_pkg::MAX_DIM) return fmca_pkg::MAX_DIM;
        return frame_len_reg;
    endfunction

    task automatic predict_item(fmca_pkg::t_kind kind, logic [15:0] samp, bit last,
                                int row, int col);
        t_stat  r;
        int     t;
        int     len;
        longint s;
        longint x;
        longint sc;
        longint mr;
        longint mc;
        longint vi;
        r = '{fmca_pkg::ST_COMMIT, '0, '0, '0, '0, '0};
        if (kind == fmca_pkg::KIND_NONE) return;
        if (kind == fmca_pkg::KIND_READ) begin
            if (col > row) begin
                t = row; row = col; col = t;
            end
            s = $signed(dim_sum[row]);
            x = $signed(pair_sum[tri_index(row, col)]);
            r.sum_value = s;
            r.cross_sum = x;
            r.frame_count = frames_in;
            if (frames_in == 0) begin
                r.status = fmca_pkg::ST_NO_FRAMES;
            end else begin
                sc = $signed(dim_sum[col]);
                mr = clamp(round_div(s, frames_in), -32768, 32767);
                mc = clamp(round_div(sc, frames_in), -32768, 32767);
                r.status = fmca_pkg::ST_READ_OK;
                r.mean_value = mr;
                r.covariance_value = clamp(round_div(x, frames_in) - mr * mc,
                                           -64'sd2147483648, 64'sd2147483647);
            end
            expected_stats.push_back(r);
            return;
        end
        if (elem_pos == 0) removing = (kind != fmca_pkg::KIND_ADD);
        if (elem_pos < fmca_pkg::MAX_DIM) elem_buf[elem_pos] = samp;
        if (!last) begin
            if (elem_pos < 127) elem_pos++;
            return;
        end
        len = effective_len();
        if (elem_pos + 1 != len) begin
            r.status = fmca_pkg::ST_LEN_ERR;
        end else if (removing && frames_in == 0) begin
            r.status = fmca_pkg::ST_EMPTY;
        end else if (!removing && frames_in >= fmca_pkg::COUNT_FULL) begin
            r.status = fmca_pkg::ST_FULL;
        end else begin
            for (int i = 0; i < len; i++) begin
                vi = $signed(elem_buf[i]);
                dim_sum[i] = removing ? dim_sum[i] - vi : dim_sum[i] + vi;
                for (int j = 0; j <= i; j++) begin
                    x = vi * longint'($signed(elem_buf[j]));
                    t = tri_index(i, j);
                    pair_sum[t] = removing ? pair_sum[t] - x : pair_sum[t] + x;
                end
            end
            frames_in = removing ? frames_in - 1 : frames_in + 1;
            r.status = fmca_pkg::ST_COMMIT;
        end
        elem_pos = 0;
        r.frame_count = frames_in;
        expected_stats.push_back(r);
    endtask

    task automatic send_item(fmca_pkg::t_kind kind, logic [15:0] samp, bit last,
                             int row, int col);
        while ($urandom_range(99) < sender_idle) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tlast  = last;
        i_s_tdata  = {4'b0, 6'(col), 6'(row), samp};
        do @(posedge i_clk); while (!o_s_tready);
        predict_item(kind, samp, last, row, col);
        if (kind != fmca_pkg::KIND_NONE) items_sent++;
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    // Waits for the block to drain, then writes the frame length.
    task automatic write_length(logic [6:0] value);
        wait (expected_stats.size() == 0);
        repeat (20) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        frame_len_reg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_frame(fmca_pkg::t_kind kind, int n);
        for (int i = 0; i < n; i++)
            send_item(kind, 16'($urandom), i == n - 1, $urandom_range(63), $urandom_range(63));
    endtask

    task automatic test_reads_and_extremes();
        write_length(7'd2);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 0, 0);
        send_frame(fmca_pkg::KIND_REMOVE, 2);
        send_item(fmca_pkg::KIND_ADD, 16'h7fff, 0, 0, 0);
        send_item(fmca_pkg::KIND_ADD, 16'h8000, 1, 0, 0);
        send_item(fmca_pkg::KIND_ADD, 16'h8000, 0, 63, 63);
        send_item(fmca_pkg::KIND_ADD, 16'h8000, 1, 63, 63);
        send_item(fmca_pkg::KIND_READ, 16'hffff, 1, 0, 0);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 1, 0);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 0, 1);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 63, 63);
        send_item(fmca_pkg::KIND_NONE, 16'hffff, 1, 63, 63);
    endtask

    task automatic test_frame_rules();
        // Wrong length, then an overlong frame that runs the position counter to its limit.
        send_frame(fmca_pkg::KIND_ADD, 3);
        send_frame(fmca_pkg::KIND_ADD, 130);
        // A read in mid-frame, and a later element whose kind differs from the first.
        send_item(fmca_pkg::KIND_ADD, 16'h0123, 0, 0, 0);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 1, 1);
        send_item(fmca_pkg::KIND_REMOVE, 16'hfedc, 1, 0, 0);
        send_frame(fmca_pkg::KIND_REMOVE, 2);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 1, 0);
    endtask

    task automatic test_length_register();
        write_length(7'd0);
        send_frame(fmca_pkg::KIND_ADD, 1);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 0, 0);
        write_length(7'd127);
        send_frame(fmca_pkg::KIND_ADD, 64);
        send_item(fmca_pkg::KIND_READ, 16'h0, 0, 63, 0);
        write_length(7'd64);
        send_frame(fmca_pkg::KIND_REMOVE, 64);
        write_length(7'd1);
        send_frame(fmca_pkg::KIND_REMOVE, 1);
    endtask

    task automatic test_random(int count);
        int     len;
        int     pick;
        int     n;
        fmca_pkg::t_kind kind;
        logic [6:0] lengths [6] = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd64};
        while (items_sent < count) begin
            write_length(($urandom_range(9) == 0) ? 7'($urandom_range(127, 65))
                         : lengths[$urandom_range(4) + ($urandom_range(39) == 0)]);
            len = effective_len();
            repeat (8) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    kind = ($urandom_range(2) == 0) ? fmca_pkg::KIND_REMOVE
                                                    : fmca_pkg::KIND_ADD;
                    n = ($urandom_range(9) == 0) ? $urandom_range(1, 9) : len;
                    send_frame(kind, n);
                end else if (pick < 95) begin
                    send_item(fmca_pkg::KIND_READ, 16'($urandom), $urandom_range(1),
                              $urandom_range(len - 1), $urandom_range(63));
                end else begin
                    send_item(fmca_pkg::KIND_NONE, 16'($urandom), $urandom_range(1),
                              $urandom_range(63), $urandom_range(63));
                end
            end
        end
    endtask

    // Receiver side: random back-pressure.
    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= receiver_idle);

    always @(posedge i_clk) begin
        t_stat exp_r;
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_stats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result, status %0d", o_m_tuser);
            end else begin
                exp_r = expected_stats.pop_front();
                if (o_m_tuser !== exp_r.status ||
                    o_m_tdata[35:0] !== exp_r.sum_value ||
                    o_m_tdata[87:36] !== exp_r.cross_sum ||
                    o_m_tdata[107:88] !== exp_r.frame_count ||
                    o_m_tdata[123:108] !== exp_r.mean_value ||
                    o_m_tdata[155:124] !== exp_r.covariance_value) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected st %0d sum %0d x %0d n %0d m %0d c %0d,",
                                  " got st %0d sum %0d x %0d n %0d m %0d c %0d"},
                            exp_r.status, exp_r.sum_value, exp_r.cross_sum,
                            exp_r.frame_count, exp_r.mean_value, exp_r.covariance_value,
                            o_m_tuser, $signed(o_m_tdata[35:0]), $signed(o_m_tdata[87:36]),
                            o_m_tdata[107:88], $signed(o_m_tdata[123:108]),
                            $signed(o_m_tdata[155:124]));
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_s_tuser = fmca_pkg::KIND_ADD;
        i_m_tready = 1'b0;
        frame_len_reg = 7'd64;
        elem_pos = 0;
        removing = 0;
        frames_in = 0;
        foreach (dim_sum[i]) dim_sum[i] = '0;
        foreach (pair_sum[i]) pair_sum[i] = '0;
        errors = 0;
        stall_cycles = 0;
        items_sent = 0;
        sender_idle = 29;
        receiver_idle = 47;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reads_and_extremes();
        test_frame_rules();
        test_length_register();
        test_random(350);
        sender_idle = 47;
        receiver_idle = 29;
        test_random(700);
        sender_idle = 0;
        receiver_idle = 0;
        test_random(1050);

        wait (expected_stats.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_stats.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
